// ===== sv/tsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the trapezoid step-period ramp.
package tsr_pkg;

  localparam logic [7:0] MAX_PERIOD = 8'd255;
  localparam int         CFG_DATA_W = 32;
  localparam int         DIV_STEPS  = 8;
  localparam int         CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CFG_TARGET_PERIOD = 2'd0,
    CFG_START_PERIOD  = 2'd1,
    CFG_TOTAL_TIME    = 2'd2,
    CFG_ACCEL_TIME    = 2'd3
  } tsr_cfg_idx_t;

  typedef enum logic [1:0] {
    PH_ACCEL   = 2'd0,
    PH_CRUISE  = 2'd1,
    PH_DECEL   = 2'd2,
    PH_OVERRUN = 2'd3
  } tsr_phase_t;

  typedef enum logic {
    FN_START = 1'b0,
    FN_TIME  = 1'b1
  } tsr_func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP_A,
    S_CALC_CE,
    S_CMP_CE,
    S_CMP_T,
    S_MUL,
    S_DIV,
    S_FIN,
    S_DONE
  } tsr_state_t;

  typedef struct packed {
    logic [7:0]  target_period;
    logic [7:0]  start_period;
    logic [31:0] total_time_us;
    logic [31:0] accel_time_us;
  } tsr_cfg_t;

  typedef struct packed {
    logic [7:0] period;
    logic       changed;
    tsr_phase_t phase;
  } tsr_res_t;

endpackage

// ===== sv/tsr_if.sv =====
`timescale 1ns / 1ps
// Request channel interfaces for the input items and the result items.
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] elapsed_us;

  modport source (output valid, func, elapsed_us, input ready);
  modport sink   (input valid, func, elapsed_us, output ready);
endinterface

interface tsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] period;
  logic       changed;
  logic [1:0] phase;

  modport source (output valid, period, changed, phase, input ready);
  modport sink   (input valid, period, changed, phase, output ready);
endinterface

// ===== sv/trapezoid_step_period_ramp.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, sequencer and result output register.
//
// Turns the time since a move start into a stepper pulse period along a
// trapezoid (accelerate, cruise, decelerate, overrun). A start request
// latches the ramp top and returns it with no compare or division step.
// For a time request, the phase is found by up to three compares and one
// cruise-end subtraction that share one 33-bit subtractor, then a ramp
// sample needs one 32x8 multiply and eight restoring division steps on the
// same subtractor, before the result is offered.
// The input is not ready while a request is in work; a finished result waits
// in the output register, so the next request is taken while it is still
// unread. Write configuration only while the block is idle.
module trapezoid_step_period_ramp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data,
  tsr_in_if.sink                       in_ch,
  tsr_out_if.source                    out_ch
);

  import tsr_pkg::*;

  tsr_cfg_t cfg_r, cfg_nxt;
  logic     out_valid_r, out_valid_nxt;
  tsr_res_t out_res_r, out_res_nxt;
  logic     res_valid, res_ready;
  tsr_res_t res;

  tsr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (tsr_cfg_idx_t'(cfg_idx))
        CFG_TARGET_PERIOD: cfg_nxt.target_period = cfg_data[7:0];
        CFG_START_PERIOD:  cfg_nxt.start_period  = cfg_data[7:0];
        CFG_TOTAL_TIME:    cfg_nxt.total_time_us = cfg_data[31:0];
        CFG_ACCEL_TIME:    cfg_nxt.accel_time_us = cfg_data[31:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // take a new result when the register is empty or drains this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.period  = out_res_r.period;
  assign out_ch.changed = out_res_r.changed;
  assign out_ch.phase   = out_res_r.phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{target_period: 8'd0, start_period: 8'd255,
                       total_time_us: 32'd0, accel_time_us: 32'd0};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

endmodule

// ===== sv/tsr_sub.sv =====
`timescale 1ns / 1ps
// Shared 33-bit subtractor used for every compare and division step.
module tsr_sub (
  input  logic [32:0] op_a,
  input  logic [32:0] op_b,
  output logic [32:0] diff,
  output logic        borrow
);

  logic [33:0] full;

  assign full   = {1'b0, op_a} - {1'b0, op_b};
  assign diff   = full[32:0];
  assign borrow = full[33];

endmodule

// ===== sv/tsr_seq.sv =====
`timescale 1ns / 1ps
// Sequencer and datapath: phase compares, multiply and long division.
module tsr_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  tsr_pkg::tsr_cfg_t cfg,
  tsr_in_if.sink         in_ch,
  output logic           res_valid,
  input  logic           res_ready,
  output tsr_pkg::tsr_res_t res
);

  import tsr_pkg::*;

  tsr_state_t state_r, state_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic [7:0]  top_r, top_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] ce_r, ce_nxt;
  logic [31:0] m_r, m_nxt;
  logic [31:0] part_r, part_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tsr_phase_t  phase_r, phase_nxt;
  tsr_res_t    res_r, res_nxt;

  logic [32:0] sub_a, sub_b, sub_diff;
  logic        sub_borrow;
  logic        neg;
  logic [7:0]  dmag;
  logic [7:0]  clamp;
  logic [39:0] prod;
  logic        rnd;
  logic [7:0]  val;

  tsr_sub u_sub (
    .op_a   (sub_a),
    .op_b   (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign neg   = cfg.target_period > top_r;
  assign dmag  = neg ? (cfg.target_period - top_r) : (top_r - cfg.target_period);
  assign clamp = (cfg.start_period > MAX_PERIOD) ? MAX_PERIOD : cfg.start_period;
  assign prod  = {8'd0, m_r} * {32'd0, dmag};
  assign rnd   = part_r != 32'd0;

  assign res = res_r;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    top_nxt     = top_r;
    t_nxt       = t_r;
    ce_nxt      = ce_r;
    m_nxt       = m_r;
    part_nxt    = part_r;
    low_nxt     = low_r;
    q_nxt       = q_r;
    cnt_nxt     = cnt_r;
    phase_nxt   = phase_r;
    res_nxt     = res_r;
    sub_a       = {1'b0, t_r};
    sub_b       = {1'b0, cfg.accel_time_us};
    in_ch.ready = 1'b0;
    res_valid   = 1'b0;
    val         = top_r;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.func == FN_START) begin
            top_nxt   = clamp;
            cur_nxt   = clamp;
            res_nxt   = '{period: clamp, changed: 1'b1, phase: PH_ACCEL};
            state_nxt = S_DONE;
          end else begin
            t_nxt     = in_ch.elapsed_us;
            state_nxt = S_CMP_A;
          end
        end
      end
      S_CMP_A: begin
        if (sub_borrow) begin
          m_nxt     = t_r;
          phase_nxt = PH_ACCEL;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_CALC_CE;
        end
      end
      S_CALC_CE: begin
        // cruise end wraps modulo 2^32
        sub_a     = {1'b0, cfg.total_time_us};
        ce_nxt    = sub_diff[31:0];
        state_nxt = S_CMP_CE;
      end
      S_CMP_CE: begin
        sub_b = {1'b0, ce_r};
        if (sub_borrow) begin
          phase_nxt = PH_CRUISE;
          state_nxt = S_FIN;
        end else begin
          // time into deceleration equals A - (T - t)
          m_nxt     = sub_diff[31:0];
          state_nxt = S_CMP_T;
        end
      end
      S_CMP_T: begin
        sub_b = {1'b0, cfg.total_time_us};
        if (sub_borrow) begin
          phase_nxt = PH_DECEL;
          state_nxt = S_MUL;
        end else begin
          phase_nxt = PH_OVERRUN;
          state_nxt = S_FIN;
        end
      end
      S_MUL: begin
        // quotient stays below 256, so the top 32 bits are already below A
        part_nxt  = prod[39:8];
        low_nxt   = prod[7:0];
        q_nxt     = 8'd0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        sub_a    = {part_r, low_r[7]};
        part_nxt = sub_borrow ? sub_a[31:0] : sub_diff[31:0];
        low_nxt  = {low_r[6:0], 1'b0};
        q_nxt    = {q_r[6:0], ~sub_borrow};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        case (phase_r)
          PH_ACCEL:   val = neg ? (top_r + q_r) : (top_r - q_r - {7'd0, rnd});
          PH_CRUISE:  val = cfg.target_period;
          PH_DECEL:   val = neg ? (cfg.target_period - q_r - {7'd0, rnd})
                                : (cfg.target_period + q_r);
          default:    val = top_r;
        endcase
        res_nxt   = '{period: val, changed: val != cur_r, phase: phase_r};
        cur_nxt   = val;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= 8'd0;
      top_r   <= 8'd0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    ce_r    <= ce_nxt;
    m_r     <= m_nxt;
    part_r  <= part_nxt;
    low_r   <= low_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ===== sim/tb_trapezoid_step_period_ramp.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the trapezoid step-period ramp with random handshake idling.
module tb_trapezoid_step_period_ramp;
  import tsr_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int ITEMS_PER_MOVE = 50;
  localparam int RANDOM_MOVES   = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [1:0]            cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsr_in_if  in_ch ();
  tsr_out_if out_ch ();

  trapezoid_step_period_ramp i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #2 clk = ~clk;

  // Local copy of the register file and ramp state
  tsr_cfg_t   cfg_model;
  logic [7:0] cur_period;
  logic [7:0] ramp_top;

  tsr_res_t   period_q[$];
  int         fail_count = 0;
  int         n_sent     = 0;
  int         n_checked  = 0;
  int         n_profiles = 0;
  bit         tx_steady  = 1'b0;
  bit         rx_steady  = 1'b0;
  bit         rx_hold_req = 1'b0;

  function automatic longint div_round_down(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint div_round_up(longint num, longint den);
    if (num >= 0) return (num + den - 1) / den;
    return -((-num) / den);
  endfunction

  // Advance the ramp state by one request and return the period it yields
  function automatic tsr_res_t predict_period(tsr_func_t f, logic [31:0] t);
    tsr_res_t    r;
    longint      top;
    longint      tgt;
    longint      d;
    longint      a;
    longint      v;
    longint      left;
    logic [31:0] cruise_end;
    logic [31:0] time_left;
    logic [7:0]  nxt;

    if (f == FN_START) begin
      ramp_top   = (cfg_model.start_period > MAX_PERIOD) ? MAX_PERIOD
                                                         : cfg_model.start_period;
      cur_period = ramp_top;
      r.period   = ramp_top;
      r.changed  = 1'b1;
      r.phase    = PH_ACCEL;
      return r;
    end
    top        = ramp_top;
    tgt        = cfg_model.target_period;
    d          = top - tgt;
    a          = cfg_model.accel_time_us;
    cruise_end = cfg_model.total_time_us - cfg_model.accel_time_us;
    if (t < cfg_model.accel_time_us) begin
      v       = top - div_round_up(longint'(t) * d, a);
      r.phase = PH_ACCEL;
    end else if (t < cruise_end) begin
      v       = tgt;
      r.phase = PH_CRUISE;
    end else if (t < cfg_model.total_time_us) begin
      time_left = cfg_model.total_time_us - t;
      left      = time_left;
      v         = tgt + div_round_down((a - left) * d, a);
      r.phase   = PH_DECEL;
    end else begin
      v       = top;
      r.phase = PH_OVERRUN;
    end
    nxt        = v[7:0];
    r.changed  = (nxt != cur_period);
    cur_period = nxt;
    r.period   = nxt;
    return r;
  endfunction

  task automatic write_reg(tsr_cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_TARGET_PERIOD: cfg_model.target_period = val[7:0];
      CFG_START_PERIOD:  cfg_model.start_period  = val[7:0];
      CFG_TOTAL_TIME:    cfg_model.total_time_us = val;
      CFG_ACCEL_TIME:    cfg_model.accel_time_us = val;
      default: ;
    endcase
  endtask

  task automatic set_profile(logic [7:0] tgt, logic [7:0] sp, logic [31:0] tot,
                             logic [31:0] acc);
    write_reg(CFG_TARGET_PERIOD, {24'd0, tgt});
    write_reg(CFG_START_PERIOD, {24'd0, sp});
    write_reg(CFG_TOTAL_TIME, tot);
    write_reg(CFG_ACCEL_TIME, acc);
    n_profiles++;
  endtask

  task automatic send_request(tsr_func_t f, logic [31:0] t);
    int gap;
    int r;

    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.elapsed_us <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    period_q.push_back(predict_period(f, t));
    n_sent++;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 65) gap = 0;
    else if (r < 95)         gap = $urandom_range(1, 3);
    else                     gap = $urandom_range(8, 30);
    // Keep valid up for back-to-back requests
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (period_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, steady stretches and one-off long holds
  initial begin
    int stall_left;
    int len;

    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_left  = RX_HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        stall_left = len - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tsr_res_t exp_res;

    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (period_q.size() == 0) begin
        $error("unexpected result: period %0d changed %0d phase %0d",
               out_ch.period, out_ch.changed, out_ch.phase);
        fail_count++;
      end else begin
        exp_res = period_q.pop_front();
        n_checked++;
        if (out_ch.period !== exp_res.period) begin
          $error("period: expected %0d, got %0d", exp_res.period, out_ch.period);
          fail_count++;
        end
        if (out_ch.changed !== exp_res.changed) begin
          $error("changed: expected %0d, got %0d", exp_res.changed, out_ch.changed);
          fail_count++;
        end
        if (out_ch.phase !== exp_res.phase) begin
          $error("phase: expected %0d, got %0d", exp_res.phase, out_ch.phase);
          fail_count++;
        end
      end
    end
  end

  // Samples with only the reset configuration and no ramp top latched yet
  task automatic test_before_start();
    send_request(FN_TIME, 32'd0);
    send_request(FN_TIME, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_basic_trapezoid();
    set_profile(8'd0, 8'd255, 32'd1000, 32'd300);
    send_request(FN_START, 32'd0);
    send_request(FN_TIME, 32'd0);
    send_request(FN_TIME, 32'd1);
    send_request(FN_TIME, 32'd299);
    send_request(FN_TIME, 32'd300);
    send_request(FN_TIME, 32'd699);
    send_request(FN_TIME, 32'd700);
    send_request(FN_TIME, 32'd999);
    send_request(FN_TIME, 32'd1000);
    drain_results();
  endtask

  // Target above the ramp top: the ramp runs upward
  task automatic test_inverted_ramp();
    set_profile(8'd200, 8'd50, 32'd100, 32'd40);
    send_request(FN_START, 32'd0);
    send_request(FN_TIME, 32'd10);
    send_request(FN_TIME, 32'd59);
    send_request(FN_TIME, 32'd75);
    send_request(FN_TIME, 32'd100);
    drain_results();
  endtask

  task automatic test_no_ramp();
    set_profile(8'd255, 8'd0, 32'd50, 32'd0);
    send_request(FN_START, 32'd0);
    send_request(FN_TIME, 32'd0);
    send_request(FN_TIME, 32'd50);
    drain_results();
  endtask

  // Move shorter than the ramp: cruise end wraps around
  task automatic test_short_move();
    set_profile(8'd3, 8'd128, 32'd10, 32'hFFFF_FFFF);
    send_request(FN_START, 32'd0);
    send_request(FN_TIME, 32'd5);
    send_request(FN_TIME, 32'hFFFF_FFFE);
    send_request(FN_TIME, 32'hFFFF_FFFF);
    drain_results();
  endtask

  function automatic logic [7:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 4));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_moves();
    logic [7:0]  tgt;
    logic [7:0]  sp;
    logic [31:0] tot;
    logic [31:0] acc;
    logic [31:0] t;
    logic [31:0] ce;
    longint      span;

    for (int p = 0; p < RANDOM_MOVES; p++) begin
      drain_results();
      tgt = pick_period();
      sp  = pick_period();
      case ($urandom_range(0, 5))
        0: begin acc = $urandom_range(1, 200); tot = 2 * acc + $urandom_range(0, 400); end
        1: begin acc = 0; tot = $urandom_range(0, 500); end
        2: begin acc = $urandom_range(1, 300); tot = $urandom_range(0, acc); end
        3: begin acc = $urandom; tot = $urandom; end
        4: begin acc = $urandom_range(1, 50); tot = 2 * acc; end
        default: begin
          acc = $urandom_range(1, 100);
          tot = 2 * acc + $urandom_range(0, 200);
          sp  = 8'($urandom_range(0, 100));
          tgt = 8'($urandom_range(101, 255));
        end
      endcase
      set_profile(tgt, sp, tot, acc);
      tx_steady = (p % 4 == 3);
      rx_steady = (p % 4 == 3);
      ce   = tot - acc;
      span = longint'(tot) + longint'(tot) / 8 + 4;
      send_request(FN_START, 32'd0);
      for (int k = 1; k < ITEMS_PER_MOVE; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          send_request(tsr_func_t'($urandom_range(0, 1)), $urandom);
        end else begin
          if ($urandom_range(0, 99) < 20) begin
            case ($urandom_range(0, 5))
              0: t = acc - 1;
              1: t = acc;
              2: t = ce - 1;
              3: t = ce;
              4: t = tot - 1;
              default: t = tot;
            endcase
          end else begin
            t = 32'((span * k) / ITEMS_PER_MOVE) + $urandom_range(0, 2);
          end
          send_request(FN_TIME, t);
        end
        // Pause the sender now and then until every result is back
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();
  endtask

  // Hold the receiver off while requests keep coming so the input stalls
  task automatic test_backpressure();
    set_profile(8'd10, 8'd250, 32'd400, 32'd150);
    tx_steady   = 1'b1;
    rx_hold_req = 1'b1;
    send_request(FN_START, 32'd0);
    for (int k = 0; k < 20; k++) send_request(FN_TIME, 32'($urandom_range(0, 450)));
    tx_steady = 1'b0;
    drain_results();
  endtask

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    cfg_model.target_period = 8'd0;
    cfg_model.start_period  = 8'd255;
    cfg_model.total_time_us = 32'd0;
    cfg_model.accel_time_us = 32'd0;
    cur_period       = 8'd0;
    ramp_top         = 8'd0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_TARGET_PERIOD;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FN_START;
    in_ch.elapsed_us = 32'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_start();
    test_basic_trapezoid();
    test_inverted_ramp();
    test_no_ramp();
    test_short_move();
    test_backpressure();
    test_random_moves();

    drain_results();
    repeat (20) @(posedge clk);
    if (period_q.size() != 0) begin
      $error("%0d expected results never arrived", period_q.size());
      fail_count++;
    end
    $display("Sent %0d start and time requests over %0d ramp profiles, %0d results checked.",
             n_sent, n_profiles, n_checked);
    $display("Covered all four phases, inverted and disabled ramps, wrapped cruise end.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tsr_pkg.sv
sv/tsr_if.sv
sv/tsr_sub.sv
sv/tsr_seq.sv
sv/trapezoid_step_period_ramp.sv
sim/tb_trapezoid_step_period_ramp.sv
